// ===== src/sfbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed field bit packer: shared definitions
// Widths, register map and the types passed between front end and back end.
// ----------------------------------------------------------------------------
package sfbp_pkg;

	localparam int SAMPLE_W = 32;
	localparam int BYTE_W   = 8;
	localparam int PEND_W   = 7;
	localparam int PCNT_W   = 3;
	localparam int CFG_W    = 6;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [CFG_W-1:0] FIELD_WIDTH_RESET = 6'd16;

	// Register index, taken from paddr[2].
	localparam logic REG_FIELD_WIDTH = 1'b0;

	// Per-field control that travels through the queue with the field bits.
	typedef struct packed {
		logic eob;
		logic clip;
	} sfbp_tag_t;

	// Back-end status seen by the top level.
	typedef struct packed {
		logic              act;
		logic [PCNT_W-1:0] pcnt;
	} sfbp_back_stat_t;

endpackage

// ===== src/sfbp_if.sv =====
// ----------------------------------------------------------------------------
// Signed field bit packer: stream interfaces
// Valid/ready channels for input samples and packed output bytes.
// ----------------------------------------------------------------------------
interface sfbp_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic               end_of_block;

	modport source (output valid, output sample_value, output end_of_block, input ready);
	modport sink   (input valid, input sample_value, input end_of_block, output ready);
endinterface

interface sfbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;
	logic       final_byte;
	logic       clipped;

	modport source (output valid, output packed_byte, output final_byte, output clipped,
		input ready);
	modport sink   (input valid, input packed_byte, input final_byte, input clipped,
		output ready);
endinterface

// ===== src/sfbp_fifo.sv =====
// ----------------------------------------------------------------------------
// Signed field bit packer: field queue
// Two-entry register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sfbp_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              valid,
	output logic              full
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wptr_q;
	logic              rptr_q;
	logic [1:0]        cnt_q;

	assign rdata = mem_q[rptr_q];
	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/sfbp_front.sv =====
// ----------------------------------------------------------------------------
// Signed field bit packer: front end
// Takes samples, saturates them into left-aligned sign-magnitude fields and
// keeps the sticky clip flag of the current block.
// ----------------------------------------------------------------------------
module sfbp_front import sfbp_pkg::*; #(
	parameter int FW = 32,
	parameter int WW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	sfbp_in_if.sink          samples,
	input  logic [CFG_W-1:0] field_width,
	input  logic             q_full,
	output logic             q_push,
	output logic [FW-1:0]    fld,
	output logic [WW-1:0]    wid,
	output sfbp_tag_t        tag
);

	localparam int MXW = (FW > SAMPLE_W) ? FW : SAMPLE_W;

	logic [SAMPLE_W-1:0] raw;
	logic [SAMPLE_W-1:0] mag;
	logic [MXW-1:0]      mag_x;
	logic [WW-1:0]       wm1;
	logic                neg;
	logic                clip_now;
	logic [FW-1:0]       maxmag;
	logic [FW-1:0]       field;
	logic                clip_seen_q;

	// Out-of-range widths are clamped to 1..FW.
	always_comb begin
		if (field_width == '0) begin
			wid = WW'(1);
		end else if (32'(field_width) > 32'(FW)) begin
			wid = WW'(FW);
		end else begin
			wid = WW'(field_width);
		end
	end

	assign raw      = samples.sample_value;
	assign neg      = raw[SAMPLE_W-1];
	assign mag      = neg ? (~raw + SAMPLE_W'(1)) : raw;
	assign mag_x    = MXW'(mag);
	assign wm1      = wid - WW'(1);
	assign clip_now = ((mag_x >> wm1) != '0);
	assign maxmag   = {FW{1'b1}} >> (WW'(FW) - wm1);

	always_comb begin
		field = clip_now ? maxmag : mag_x[FW-1:0];
		field = field | (FW'(neg) << wm1);
	end

	// The back end consumes from the top bit down, so the field is left-aligned.
	assign fld = field << (WW'(FW) - wid);

	assign samples.ready = !q_full;
	assign q_push        = samples.valid && !q_full;
	assign tag.eob       = samples.end_of_block;
	assign tag.clip      = clip_seen_q || clip_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_seen_q <= 1'b0;
		end else if (q_push) begin
			clip_seen_q <= samples.end_of_block ? 1'b0 : (clip_seen_q || clip_now);
		end
	end

endmodule

// ===== src/sfbp_back.sv =====
// ----------------------------------------------------------------------------
// Signed field bit packer: back end
// Merges queued fields with the pending bits and emits one byte a cycle while
// the output is not held off, including the closing byte of a block, zero-padded.
// ----------------------------------------------------------------------------
module sfbp_back import sfbp_pkg::*; #(
	parameter int FW = 32,
	parameter int WW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  logic [FW-1:0]   q_fld,
	input  logic [WW-1:0]   q_wid,
	input  sfbp_tag_t       q_tag,
	output logic            q_pop,
	sfbp_out_if.source      stream,
	output sfbp_back_stat_t stat
);

	localparam int TW = $clog2(FW + BYTE_W);

	logic [FW-1:0]        fld_q;
	logic [WW-1:0]        rem_q;
	logic                 eob_q;
	logic                 clip_q;
	logic                 act_q;
	logic [PEND_W-1:0]    pend_q;
	logic [PCNT_W-1:0]    pcnt_q;
	logic                 ovalid_q;
	logic [BYTE_W-1:0]    byte_q;
	logic                 fin_q;
	logic                 oclip_q;

	logic [FW+BYTE_W-1:0] fld_pad;
	logic [BYTE_W-1:0]    top8;
	logic [TW-1:0]        total;
	logic                 full_byte;
	logic                 need_out;
	logic                 adv;
	logic                 step;
	logic                 emit;
	logic                 finish;
	logic [3:0]           take;
	logic [3:0]           r4;
	logic [WW-1:0]        rem_after;
	logic [BYTE_W-1:0]    byte_v;
	logic [BYTE_W-1:0]    absorb_v;

	assign fld_pad   = {fld_q, BYTE_W'(0)};
	assign top8      = fld_pad[FW+BYTE_W-1 -: BYTE_W];
	assign total     = TW'(pcnt_q) + TW'(rem_q);
	assign full_byte = (total >= TW'(BYTE_W));
	assign need_out  = full_byte || eob_q;
	assign adv       = !ovalid_q || stream.ready;
	assign step      = act_q && (!need_out || adv);
	assign emit      = step && need_out;

	assign take      = 4'd8 - {1'b0, pcnt_q};
	assign r4        = 4'(rem_q);
	assign rem_after = WW'(TW'(rem_q) - TW'(take));

	// Pending bits sit on top, the next field bits fill the rest of the byte.
	assign byte_v   = (BYTE_W'({1'b0, pend_q}) << take) | (top8 >> pcnt_q);
	assign absorb_v = (BYTE_W'({1'b0, pend_q}) << r4) | (top8 >> (4'd8 - r4));

	// A non-closing entry retires on its last byte or on absorbing leftover bits.
	assign finish = step && (full_byte ? ((rem_after == '0) && !eob_q) : 1'b1);
	assign q_pop  = q_valid && (!act_q || finish);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			fld_q  <= q_fld;
			rem_q  <= q_wid;
			eob_q  <= q_tag.eob;
			clip_q <= q_tag.clip;
		end else if (step && full_byte) begin
			fld_q <= fld_q << take;
			rem_q <= rem_after;
		end
		if (emit) begin
			byte_q  <= byte_v;
			fin_q   <= !full_byte;
			oclip_q <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			pend_q   <= '0;
			pcnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				act_q <= 1'b1;
			end else if (finish) begin
				act_q <= 1'b0;
			end
			if (step) begin
				if (need_out) begin
					pend_q <= '0;
					pcnt_q <= '0;
				end else begin
					pend_q <= absorb_v[PEND_W-1:0];
					pcnt_q <= pcnt_q + r4[PCNT_W-1:0];
				end
			end
			if (adv) begin
				ovalid_q <= emit;
			end
		end
	end

	assign stream.valid       = ovalid_q;
	assign stream.packed_byte = byte_q;
	assign stream.final_byte  = fin_q;
	assign stream.clipped     = oclip_q;

	assign stat.act  = act_q;
	assign stat.pcnt = pcnt_q;

endmodule

// ===== src/signed_field_bit_packer.sv =====
// ----------------------------------------------------------------------------
// Signed field bit packer
// Packs signed samples as saturated sign-magnitude fields into a byte stream.
// ----------------------------------------------------------------------------
//  Channel   Role      Transaction
//  samples   sink      one sample_value with its end_of_block mark
//  stream    source    one packed byte with final_byte and clipped flags
//  APB       slave     field_width register at byte address 0
//
//  An accepted sample is written into the queue at the accepting edge. The back
//  end then emits each byte that the field completes and handles the bits left
//  over (absorbed into the pending byte or sent as the closing byte). For a
//  32-bit field the byte-wide output register sets the sample rate. With the
//  back end idle, a sample passes the queue and the back-end field register
//  before its first byte is valid at the output. A two-entry queue lets samples
//  be taken while bytes wait at the output. Reset clears all control state.
// ----------------------------------------------------------------------------
module signed_field_bit_packer import sfbp_pkg::*; #(
	parameter int MAX_FIELD_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	sfbp_in_if.sink           samples,
	sfbp_out_if.source        stream,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int FW     = MAX_FIELD_WIDTH;
	localparam int WW     = $clog2(FW + 1);
	localparam int TAG_W  = $bits(sfbp_tag_t);
	localparam int DATA_W = FW + WW + TAG_W;

	logic [CFG_W-1:0]  field_width_q;
	logic              cfg_wr;

	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	logic              q_full;
	logic [FW-1:0]     f_fld;
	logic [WW-1:0]     f_wid;
	sfbp_tag_t         f_tag;
	logic [DATA_W-1:0] q_rdata;
	sfbp_back_stat_t   bk_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FIELD_WIDTH);
	assign prdata = (paddr[2] == REG_FIELD_WIDTH) ? APB_DW'(field_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= FIELD_WIDTH_RESET;
		end else if (cfg_wr) begin
			field_width_q <= pwdata[CFG_W-1:0];
		end
	end

	sfbp_front #(
		.FW(FW),
		.WW(WW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.field_width (field_width_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.fld         (f_fld),
		.wid         (f_wid),
		.tag         (f_tag)
	);

	sfbp_fifo #(
		.DATA_W(DATA_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_fld, f_wid, f_tag}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid),
		.full   (q_full)
	);

	sfbp_back #(
		.FW(FW),
		.WW(WW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_fld   (q_rdata[DATA_W-1 -: FW]),
		.q_wid   (q_rdata[TAG_W +: WW]),
		.q_tag   (sfbp_tag_t'(q_rdata[TAG_W-1:0])),
		.q_pop   (q_pop),
		.stream  (stream),
		.stat    (bk_stat)
	);

	// The queue never reports full while it reports empty.
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && !q_valid))
		else $error("queue full while empty");

	// An accepted sample is held in the queue in the following cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> q_valid)
		else $error("accepted sample not queued");

	// A byte can only appear while the back end is working on a field.
	a_byte_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stream.valid) |-> $past(bk_stat.act))
		else $error("output byte without an active field");

	// A freshly emitted closing byte leaves no bits pending.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(stream.valid) && stream.final_byte) |-> (bk_stat.pcnt == '0))
		else $error("pending bits left after a closing byte");

endmodule

// ===== tb/signed_field_bit_packer_test.sv =====
// ----------------------------------------------------------------------------
// Signed field bit packer: block-level testbench
// Feeds signed samples through the sample channel under several field widths,
// predicts the packed byte stream and compares every output transaction.
// ----------------------------------------------------------------------------
module signed_field_bit_packer_test import sfbp_pkg::*;;

	localparam int FIELD_MAX    = 32;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;

	typedef struct {
		logic signed [31:0] value;
		logic               eob;
	} sample_t;

	typedef struct {
		logic [7:0] data;
		logic       fin;
		logic       clip;
	} packed_byte_t;

	logic clk;
	logic arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sfbp_in_if  samples_if();
	sfbp_out_if stream_if();

	signed_field_bit_packer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.stream  (stream_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sample_t      pending_samples[$];
	packed_byte_t expected_bytes[$];

	// Shadow of the field width register and of the packer's own state.
	logic [CFG_W-1:0]  width_reg  = FIELD_WIDTH_RESET;
	logic [PEND_W-1:0] held_bits  = '0;
	logic [PCNT_W-1:0] held_count = '0;
	logic              clip_flag  = 1'b0;

	int mismatch_count = 0;
	bit steady         = 1'b0;
	bit hold_req       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3600000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic push_byte(input logic [7:0] data, input logic fin);
		packed_byte_t b;
		b.data = data;
		b.fin  = fin;
		b.clip = clip_flag;
		expected_bytes.push_back(b);
	endtask

	// Turns one accepted sample into its sign-magnitude field and appends every
	// byte that the field completes, plus the closing byte at the end of a block.
	task automatic pack_field(input logic signed [31:0] value, input logic eob);
		int          w;
		int          j;
		logic        neg;
		logic [32:0] mag;
		logic [32:0] maxmag;
		logic [31:0] field;
		logic [7:0]  acc;
		logic [3:0]  cnt;
		logic [7:0]  flush;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > FIELD_MAX) w = FIELD_MAX;
		neg    = value[31];
		mag    = neg ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
		maxmag = (33'd1 << (w - 1)) - 33'd1;
		if (mag > maxmag) begin
			mag       = maxmag;
			clip_flag = 1'b1;
		end
		field = ({31'd0, neg} << (w - 1)) | mag[31:0];
		acc   = {1'b0, held_bits};
		cnt   = {1'b0, held_count};
		for (j = w - 1; j >= 0; j--) begin
			acc = {acc[6:0], field[j]};
			cnt = cnt + 4'd1;
			if (cnt == 4'd8) begin
				push_byte(acc, 1'b0);
				acc = '0;
				cnt = '0;
			end
		end
		if (eob) begin
			flush = acc << (8 - cnt);
			push_byte(flush, 1'b1);
			acc       = '0;
			cnt       = '0;
			clip_flag = 1'b0;
		end
		held_bits  = acc[PEND_W-1:0];
		held_count = cnt[PCNT_W-1:0];
	endtask

	// Sample driver: holds each sample until it is taken, then may idle.
	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		bit      take;
		if (!arst_n) begin
			samples_if.valid        <= 1'b0;
			samples_if.sample_value <= '0;
			samples_if.end_of_block <= 1'b0;
		end else begin
			take = samples_if.valid && samples_if.ready;
			if (take) pack_field(samples_if.sample_value, samples_if.end_of_block);
			if (!samples_if.valid || take) begin
				if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
					s = pending_samples.pop_front();
					samples_if.valid        <= 1'b1;
					samples_if.sample_value <= s.value;
					samples_if.end_of_block <= s.eob;
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// Byte monitor: checks each output transaction and drives ready.
	always @(posedge clk or negedge arst_n) begin
		packed_byte_t exp_b;
		int           hold_cnt;
		bit           hold_done;
		if (!arst_n) begin
			stream_if.ready <= 1'b0;
			hold_cnt  = 0;
			hold_done = 1'b0;
		end else begin
			if (stream_if.valid && stream_if.ready) begin
				if (expected_bytes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected byte %02h final %0b clipped %0b",
							stream_if.packed_byte, stream_if.final_byte, stream_if.clipped);
				end else begin
					exp_b = expected_bytes.pop_front();
					if (stream_if.packed_byte !== exp_b.data || stream_if.final_byte !== exp_b.fin ||
						stream_if.clipped !== exp_b.clip) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
								exp_b.data, exp_b.fin, exp_b.clip, stream_if.packed_byte,
								stream_if.final_byte, stream_if.clipped);
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_cnt  = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				stream_if.ready <= 1'b0;
			end else begin
				stream_if.ready <= steady || $urandom_range(99) >= 34;
			end
		end
	end

	task automatic add_sample(input logic signed [31:0] value, input logic eob);
		sample_t s;
		s.value = value;
		s.eob   = eob;
		pending_samples.push_back(s);
	endtask

	task automatic write_width(input logic [CFG_W-1:0] w);
		logic [APB_DW-1:0] d;
		d      = $urandom();
		d[5:0] = w;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_FIELD_WIDTH, 2'b00};
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		width_reg = w;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Fields narrower than a byte may leave the packer busy with no byte
	// outstanding, so the wait goes on past the last expected byte.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || samples_if.valid || expected_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed blocks of in-range values, with saturating values,
	// raw random words and extremes mixed in.
	task automatic add_random_run(input int count);
		int          ew;
		int          i;
		int          left;
		int          pick;
		logic [31:0] maxm;
		logic [31:0] mag;
		logic [31:0] v;
		logic        neg;
		logic        eob;
		ew = width_reg;
		if (ew < 1) ew = 1;
		if (ew > FIELD_MAX) ew = FIELD_MAX;
		maxm = (ew == 1) ? 32'd0 : ((32'd1 << (ew - 1)) - 32'd1);
		left = 0;
		for (i = 0; i < count; i++) begin
			if (left == 0) left = $urandom_range(1, 12);
			left--;
			eob = (left == 0) || ($urandom_range(99) < 4);
			if (eob) left = 0;
			neg  = $urandom_range(1);
			pick = $urandom_range(99);
			if (pick < 50) begin
				mag = $urandom_range(0, maxm);
				v   = neg ? (32'd0 - mag) : mag;
			end else if (pick < 65) begin
				mag = maxm + 32'd1;
				v   = neg ? (32'd0 - mag) : mag;
			end else if (pick < 90) begin
				v = $urandom();
			end else begin
				case ($urandom_range(4))
					0: v = 32'h0000_0000;
					1: v = 32'h0000_0001;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h7FFF_FFFF;
					default: v = 32'h8000_0000;
				endcase
			end
			add_sample(v, eob);
		end
	endtask

	initial begin
		int k;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset width of sixteen: in range, just over, and the most negative value.
		add_sample(32'sd32767, 1'b0);
		add_sample(-32'sd32768, 1'b0);
		add_sample(32'sd0, 1'b0);
		add_sample(32'h8000_0000, 1'b1);
		wait_idle();

		// A one-bit field holds the sign alone; any nonzero magnitude saturates.
		write_width(6'd1);
		@(negedge clk);
		add_sample(32'sd0, 1'b0);
		add_sample(32'sd7, 1'b0);
		add_sample(-32'sd1, 1'b1);
		wait_idle();

		write_width(6'd32);
		@(negedge clk);
		add_sample(32'h8000_0000, 1'b0);
		add_sample(32'h7FFF_FFFF, 1'b0);
		add_sample(-32'sd2147483647, 1'b1);
		wait_idle();

		// Out-of-range widths act as the nearest legal width.
		write_width(6'd0);
		@(negedge clk);
		add_sample(32'sd1, 1'b0);
		add_sample(32'sd0, 1'b1);
		wait_idle();

		write_width(6'd63);
		@(negedge clk);
		add_sample(-32'sd5, 1'b1);
		wait_idle();

		write_width(6'd33);
		@(negedge clk);
		add_sample(32'sd5, 1'b1);
		wait_idle();

		// Byte-wide fields leave nothing pending, so the closing byte is empty.
		write_width(6'd8);
		@(negedge clk);
		add_sample(32'sd100, 1'b1);
		add_sample(32'sd127, 1'b0);
		add_sample(-32'sd128, 1'b1);
		wait_idle();

		write_width(6'd5);
		@(negedge clk);
		add_random_run(30);
		wait_idle();

		// The receiver holds off for a long stretch while samples keep coming.
		write_width(6'd32);
		@(negedge clk);
		add_random_run(30);
		hold_req = 1'b1;
		wait_idle();

		write_width(6'd1);
		@(negedge clk);
		add_random_run(30);
		wait_idle();

		write_width(6'd12);
		@(negedge clk);
		add_random_run(30);
		wait_idle();

		write_width(6'd0);
		@(negedge clk);
		add_random_run(25);
		wait_idle();

		write_width(6'd63);
		@(negedge clk);
		add_random_run(30);
		wait_idle();

		write_width(6'd24);
		@(negedge clk);
		steady = 1'b1;
		add_random_run(30);
		wait_idle();
		steady = 1'b0;

		write_width(6'($urandom_range(2, 31)));
		@(negedge clk);
		add_random_run(30);
		wait_idle();

		write_width(6'd8);
		@(negedge clk);
		add_random_run(30);
		wait_idle();

		write_width(6'($urandom_range(33, 63)));
		@(negedge clk);
		add_random_run(25);
		wait_idle();

		write_width(6'($urandom_range(2, 31)));
		@(negedge clk);
		add_random_run(20);

		do @(negedge clk); while (pending_samples.size() != 0 || samples_if.valid);
		for (k = 0; k < DRAIN_LIMIT && expected_bytes.size() != 0; k++) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_bytes.size() != 0) begin
			$display("%0d expected bytes never arrived", expected_bytes.size());
			mismatch_count += expected_bytes.size();
		end
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/sfbp_pkg.sv
src/sfbp_if.sv
src/sfbp_fifo.sv
src/sfbp_front.sv
src/sfbp_back.sv
src/signed_field_bit_packer.sv
tb/signed_field_bit_packer_test.sv
